// File: rtl/core/tilt_compensated_heading_macros.svh
// Assertion macros for the tilt-compensated heading block.
// Used by the port checker; depends on nothing else.
`ifndef TILT_COMPENSATED_HEADING_MACROS_SVH
`define TILT_COMPENSATED_HEADING_MACROS_SVH

// Plain property, sampled on the rising edge, off during reset.
`define TCH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when ante holds, cons must hold as written.
`define TCH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

`endif

// File: rtl/core/tch_pkg.sv
// Shared types, constants and tables for the tilt-compensated heading block.
// No dependencies; imported by every module of the block.
package tch_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_CELLS    = 17;
    localparam int DIV_CELLS     = 16;
    localparam int HEAD_W        = 13;

    // accept-to-strobe distance in clock cycles
    localparam int LATENCY = 2 + SQRT_CELLS + DIV_CELLS + 1 + SQRT_CELLS + 3 + 1
                             + CORDIC_STAGES + 2;

    localparam logic [HEAD_W-1:0] FULL_TURN  = 13'd5760;
    localparam logic [HEAD_W-1:0] DECL_RESET = 13'd176;
    localparam logic [23:0] HALF_TURN_FINE   = 24'd11796480;
    localparam logic signed [25:0] QUARTER_TURN_FINE = 26'sd5898240;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
    } t_in;

    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        logic              degenerate;
    } t_out;

    // square root cell state: remainder v - root^2 and partial root
    typedef struct packed {
        logic [35:0] rem;
        logic [16:0] root;
    } t_sqrt;

    // divider cell state: remainder, partial quotient, divisor
    typedef struct packed {
        logic [31:0] rem;
        logic [15:0] quo;
        logic [15:0] dvs;
    } t_div;

    // vectoring CORDIC cell state, angle in 2^-16 degree
    typedef struct packed {
        logic signed [51:0] x;
        logic signed [51:0] y;
        logic signed [25:0] z;
    } t_cord;

    // arctan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic logic [21:0] atan_fine(input logic [4:0] idx);
        logic [21:0] a;
        unique case (idx)
            5'd0:  a = 22'd2949120;
            5'd1:  a = 22'd1740967;
            5'd2:  a = 22'd919879;
            5'd3:  a = 22'd466945;
            5'd4:  a = 22'd234379;
            5'd5:  a = 22'd117304;
            5'd6:  a = 22'd58666;
            5'd7:  a = 22'd29335;
            5'd8:  a = 22'd14668;
            5'd9:  a = 22'd7334;
            5'd10: a = 22'd3667;
            5'd11: a = 22'd1833;
            5'd12: a = 22'd917;
            5'd13: a = 22'd458;
            5'd14: a = 22'd229;
            5'd15: a = 22'd115;
            5'd16: a = 22'd57;
            5'd17: a = 22'd29;
            5'd18: a = 22'd14;
            5'd19: a = 22'd7;
            5'd20: a = 22'd4;
            5'd21: a = 22'd2;
            5'd22: a = 22'd1;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/core/tch_sqrt_cell.sv
// One bit of a pipelined integer square root.
// Depends on tch_pkg for the cell state type.
module tch_sqrt_cell (
    input  logic          i_clk,
    input  logic [4:0]    i_bit,
    input  tch_pkg::t_sqrt i_st,
    output tch_pkg::t_sqrt o_st
);
    import tch_pkg::*;

    t_sqrt       r_st;
    t_sqrt       n_st;
    logic [35:0] trial;
    logic [5:0]  sh;

    always_comb begin
        sh    = {1'b0, i_bit} + 6'd1;
        trial = ({19'b0, i_st.root} << sh) + (36'd1 << {i_bit, 1'b0});
        n_st  = i_st;
        // keep the bit when (root + 2^bit)^2 still fits
        if (i_st.rem >= trial) begin
            n_st.rem  = i_st.rem - trial;
            n_st.root = i_st.root | (17'd1 << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
    end

    assign o_st = r_st;

endmodule

// File: rtl/core/tch_div_cell.sv
// One quotient bit of a pipelined restoring divider.
// Depends on tch_pkg for the cell state type.
module tch_div_cell (
    input  logic         i_clk,
    input  logic [3:0]   i_bit,
    input  tch_pkg::t_div i_st,
    output tch_pkg::t_div o_st
);
    import tch_pkg::*;

    t_div        r_st;
    t_div        n_st;
    logic [31:0] trial;

    always_comb begin
        trial = {16'b0, i_st.dvs} << i_bit;
        n_st  = i_st;
        if (i_st.rem >= trial) begin
            n_st.rem = i_st.rem - trial;
            n_st.quo = i_st.quo | (16'd1 << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
    end

    assign o_st = r_st;

endmodule

// File: rtl/core/tch_cordic_cell.sv
// One micro-rotation of a vectoring CORDIC, driving y toward zero.
// Depends on tch_pkg for the state type and the arctangent table.
module tch_cordic_cell (
    input  logic          i_clk,
    input  logic [4:0]    i_step,
    input  tch_pkg::t_cord i_st,
    output tch_pkg::t_cord o_st
);
    import tch_pkg::*;

    t_cord              r_st;
    t_cord              n_st;
    logic signed [51:0] xs;
    logic signed [51:0] ys;
    logic signed [25:0] ang;

    always_comb begin
        xs  = i_st.x >>> i_step;
        ys  = i_st.y >>> i_step;
        ang = $signed({4'b0, atan_fine(i_step)});
        if (!i_st.y[51]) begin
            n_st.x = i_st.x + ys;
            n_st.y = i_st.y - xs;
            n_st.z = i_st.z + ang;
        end else begin
            n_st.x = i_st.x - ys;
            n_st.y = i_st.y + xs;
            n_st.z = i_st.z - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
    end

    assign o_st = r_st;

endmodule

// File: rtl/core/tilt_compensated_heading.sv
// Top level of the tilt-compensated compass heading pipeline.
// Depends on tch_pkg, tch_sqrt_cell, tch_div_cell and tch_cordic_cell.
//
// Fully pipelined: one sensor sample may be started in every clock cycle,
// and busy stays low. Each sample passes, in order, through the squares
// register, the sum register, a 17-cell square root for the accelerometer
// norm, two 16-cell dividers for the sines, the signed-sine register, two
// 17-cell square roots for the cosines, a three-stage tilt rotation, the
// CORDIC pre-rotation register, a CORDIC_STAGES-cell vectoring CORDIC, the
// clamp register and the output register. A result beat is shown for one cycle
// with o_valid; the receiver cannot stall it, so it must take every beat.
// The declination register is written through its own channel, which is
// always ready; write it only while no sample is in flight. Heading is in
// 1/16 degree; degenerate flags a zero accelerometer vector or a zero
// horizontal field, and then the heading is 0.
module tilt_compensated_heading (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tch_pkg::t_in                i_in,
    output logic                        o_valid,
    output tch_pkg::t_out               o_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tch_pkg::HEAD_W-1:0]  i_cfg_data
);
    import tch_pkg::*;

    localparam int SQ = SQRT_CELLS;
    localparam int DV = DIV_CELLS;
    localparam int NC = CORDIC_STAGES;

    // side data that rides along the norm and divider chains
    typedef struct packed {
        logic               deg;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
    } t_raw;

    // side data that rides along the cosine chains
    typedef struct packed {
        logic               deg;
        logic signed [16:0] sr;
        logic signed [16:0] sp;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
    } t_trig;

    logic accept;

    // The pipeline never holds off a sample, and the register port never
    // waits.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // ---------------- declination register ----------------
    logic [HEAD_W-1:0] r_decl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= DECL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_decl <= i_cfg_data;
        end
    end

    // ---------------- squares and their sum ----------------
    logic        r1_vld;
    logic [30:0] r1_sqx;
    logic [30:0] r1_sqy;
    logic [30:0] r1_sqz;
    t_raw        r1_raw;
    logic        r2_vld;
    logic [32:0] r2_n2;
    t_raw        r2_raw;
    logic [32:0] n_n2;

    assign n_n2 = 33'(r1_sqx) + 33'(r1_sqy) + 33'(r1_sqz);

    always_ff @(posedge i_clk) begin
        r1_sqx     <= 31'(i_in.accel_x * i_in.accel_x);
        r1_sqy     <= 31'(i_in.accel_y * i_in.accel_y);
        r1_sqz     <= 31'(i_in.accel_z * i_in.accel_z);
        r1_raw.deg <= 1'b0;
        r1_raw.ax  <= i_in.accel_x;
        r1_raw.ay  <= i_in.accel_y;
        r1_raw.mx  <= i_in.mag_x;
        r1_raw.my  <= i_in.mag_y;
        r1_raw.mz  <= i_in.mag_z;
        r2_n2      <= n_n2;
        // zero-length accelerometer vector: flag it and let garbage flow
        r2_raw     <= '{deg: (n_n2 == 33'd0), ax: r1_raw.ax, ay: r1_raw.ay,
                        mx: r1_raw.mx, my: r1_raw.my, mz: r1_raw.mz};
    end

    // ---------------- accelerometer norm: square root chain ----------------
    t_sqrt w_nrm [SQ+1];
    logic  r_nv  [SQ];
    t_raw  r_nraw [SQ];

    assign w_nrm[0] = '{rem: 36'(r2_n2), root: 17'd0};

    for (genvar k = 0; k < SQ; k++) begin : g_norm
        tch_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_bit (5'(SQ - 1 - k)),
            .i_st  (w_nrm[k]),
            .o_st  (w_nrm[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_nraw[0] <= r2_raw;
        for (int k = 1; k < SQ; k++) begin
            r_nraw[k] <= r_nraw[k-1];
        end
    end

    // ---------------- sines: two divider chains sharing the norm ----------------
    t_raw        nraw;
    logic [15:0] norm;
    logic [15:0] axm;
    logic [15:0] aym;
    t_div        w_dx [DV+1];
    t_div        w_dy [DV+1];
    logic        r_dv  [DV];
    t_raw        r_draw [DV];

    assign nraw = r_nraw[SQ-1];
    assign norm = w_nrm[SQ].root[15:0];
    // magnitudes; the most negative count maps to 0x8000, as wanted
    assign axm  = nraw.ax[15] ? (~nraw.ax + 16'd1) : nraw.ax;
    assign aym  = nraw.ay[15] ? (~nraw.ay + 16'd1) : nraw.ay;

    assign w_dx[0] = '{rem: {1'b0, axm, 15'b0}, quo: 16'd0, dvs: norm};
    assign w_dy[0] = '{rem: {1'b0, aym, 15'b0}, quo: 16'd0, dvs: norm};

    for (genvar k = 0; k < DV; k++) begin : g_div
        tch_div_cell u_dx (
            .i_clk (i_clk),
            .i_bit (4'(DV - 1 - k)),
            .i_st  (w_dx[k]),
            .o_st  (w_dx[k+1])
        );
        tch_div_cell u_dy (
            .i_clk (i_clk),
            .i_bit (4'(DV - 1 - k)),
            .i_st  (w_dy[k]),
            .o_st  (w_dy[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_draw[0] <= nraw;
        for (int k = 1; k < DV; k++) begin
            r_draw[k] <= r_draw[k-1];
        end
    end

    // ---------------- signed sines and their squares ----------------
    t_raw        draw;
    logic [15:0] qx;
    logic [15:0] qy;
    logic        r3_vld;
    t_trig       r3_trig;
    logic [30:0] r3_sqp;
    logic [30:0] r3_sqr;

    assign draw = r_draw[DV-1];
    assign qx   = w_dx[DV].quo;
    assign qy   = w_dy[DV].quo;

    always_ff @(posedge i_clk) begin
        // truncating division: quotient takes the sign of the dividend
        r3_trig.deg <= draw.deg;
        r3_trig.sp  <= draw.ax[15] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        r3_trig.sr  <= draw.ay[15] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        r3_trig.mx  <= draw.mx;
        r3_trig.my  <= draw.my;
        r3_trig.mz  <= draw.mz;
        r3_sqp      <= 31'(qx * qx);
        r3_sqr      <= 31'(qy * qy);
    end

    // ---------------- cosines: two square root chains ----------------
    t_sqrt w_cp [SQ+1];
    t_sqrt w_cr [SQ+1];
    logic  r_cv   [SQ];
    t_trig r_ctrig [SQ];

    assign w_cp[0] = '{rem: 36'(31'h4000_0000 - r3_sqp), root: 17'd0};
    assign w_cr[0] = '{rem: 36'(31'h4000_0000 - r3_sqr), root: 17'd0};

    for (genvar k = 0; k < SQ; k++) begin : g_cos
        tch_sqrt_cell u_cp (
            .i_clk (i_clk),
            .i_bit (5'(SQ - 1 - k)),
            .i_st  (w_cp[k]),
            .o_st  (w_cp[k+1])
        );
        tch_sqrt_cell u_cr (
            .i_clk (i_clk),
            .i_bit (5'(SQ - 1 - k)),
            .i_st  (w_cr[k]),
            .o_st  (w_cr[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_ctrig[0] <= r3_trig;
        for (int k = 1; k < SQ; k++) begin
            r_ctrig[k] <= r_ctrig[k-1];
        end
    end

    // ---------------- tilt rotation, three stages ----------------
    t_trig              ctrig;
    logic signed [17:0] cp18;
    logic signed [17:0] cr18;
    logic               r4_vld;
    logic               r4_deg;
    logic signed [33:0] r4_mxcp;
    logic signed [32:0] r4_mzsp;
    logic signed [33:0] r4_srsp;
    logic signed [34:0] r4_srcp;
    logic signed [33:0] r4_mycr;
    logic signed [15:0] r4_mx;
    logic signed [15:0] r4_mz;

    assign ctrig = r_ctrig[SQ-1];
    assign cp18  = $signed({1'b0, w_cp[SQ].root});
    assign cr18  = $signed({1'b0, w_cr[SQ].root});

    always_ff @(posedge i_clk) begin
        r4_deg  <= ctrig.deg;
        r4_mxcp <= $signed(ctrig.mx) * cp18;
        r4_mzsp <= $signed(ctrig.mz) * $signed(ctrig.sp);
        r4_srsp <= $signed(ctrig.sr) * $signed(ctrig.sp);
        r4_srcp <= $signed(ctrig.sr) * cp18;
        r4_mycr <= $signed(ctrig.my) * cr18;
        r4_mx   <= ctrig.mx;
        r4_mz   <= ctrig.mz;
    end

    logic               r5_vld;
    logic               r5_deg;
    logic signed [47:0] r5_tx;
    logic signed [47:0] r5_a;
    logic signed [47:0] r5_b;
    logic signed [47:0] r5_c;
    logic signed [49:0] n_a;
    logic signed [50:0] n_b;

    assign n_a = r4_mx * r4_srsp;
    assign n_b = r4_mz * r4_srcp;

    always_ff @(posedge i_clk) begin
        r5_deg <= r4_deg;
        r5_tx  <= (48'(r4_mxcp) + 48'(r4_mzsp)) <<< 15;
        r5_a   <= n_a[47:0];
        r5_b   <= n_b[47:0];
        r5_c   <= 48'(r4_mycr) <<< 15;
    end

    logic               r6_vld;
    logic               r6_deg;
    logic signed [47:0] r6_tx;
    logic signed [47:0] r6_ty;
    logic signed [47:0] n_ty;

    assign n_ty = r5_a + r5_c - r5_b;

    always_ff @(posedge i_clk) begin
        r6_tx  <= r5_tx;
        r6_ty  <= n_ty;
        // zero horizontal field: no angle to find
        r6_deg <= r5_deg || ((r5_tx == 48'sd0) && (n_ty == 48'sd0));
    end

    // ---------------- CORDIC: pre-rotation, then the cell chain ----------------
    logic signed [47:0] tyabs;
    logic signed [51:0] x52;
    logic signed [51:0] y52;
    t_cord              n_c0;
    t_cord              r7_cord;
    logic               r7_vld;
    logic               r7_deg;
    logic               r7_mir;

    assign tyabs = r6_ty[47] ? -r6_ty : r6_ty;
    assign x52   = 52'(r6_tx);
    assign y52   = 52'(tyabs);

    always_comb begin
        n_c0 = '{x: x52, y: y52, z: 26'sd0};
        // left half plane: turn by -90 degrees and start the angle at 90
        if (r6_tx[47]) begin
            n_c0 = '{x: y52, y: -x52, z: QUARTER_TURN_FINE};
        end
    end

    always_ff @(posedge i_clk) begin
        r7_cord <= n_c0;
        r7_deg  <= r6_deg;
        r7_mir  <= !r6_ty[47] && (r6_ty != 48'sd0);
    end

    t_cord w_cd   [NC+1];
    logic  r_kv   [NC];
    logic  r_kdeg [NC];
    logic  r_kmir [NC];

    assign w_cd[0] = r7_cord;

    for (genvar k = 0; k < NC; k++) begin : g_cordic
        tch_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_step (5'(k)),
            .i_st   (w_cd[k]),
            .o_st   (w_cd[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_kdeg[0] <= r7_deg;
        r_kmir[0] <= r7_mir;
        for (int k = 1; k < NC; k++) begin
            r_kdeg[k] <= r_kdeg[k-1];
            r_kmir[k] <= r_kmir[k-1];
        end
    end

    // ---------------- clamp and round the angle ----------------
    logic signed [25:0] zf;
    logic [23:0]        zc;
    logic [23:0]        zr;
    logic               r8_vld;
    logic               r8_deg;
    logic               r8_mir;
    logic [11:0]        r8_ang;

    assign zf = w_cd[NC].z;

    always_comb begin
        // clamp to 0..180 degrees
        if (zf[25]) begin
            zc = 24'd0;
        end else if (zf[24:0] > {1'b0, HALF_TURN_FINE}) begin
            zc = HALF_TURN_FINE;
        end else begin
            zc = zf[23:0];
        end
        zr = zc + 24'd2048;
    end

    always_ff @(posedge i_clk) begin
        r8_ang <= zr[23:12];
        r8_deg <= r_kdeg[NC-1];
        r8_mir <= r_kmir[NC-1];
    end

    // ---------------- mirror, declination, single wrap ----------------
    logic [HEAD_W-1:0] hmir;
    logic [HEAD_W:0]   hsum;
    logic [HEAD_W-1:0] hwrap;
    t_out              r_out;
    logic              r_ovld;

    always_comb begin
        hmir  = r8_mir ? {1'b0, r8_ang} : (FULL_TURN - {1'b0, r8_ang});
        hsum  = {1'b0, hmir} + {1'b0, r_decl};
        hwrap = (hsum > {1'b0, FULL_TURN}) ? HEAD_W'(hsum - {1'b0, FULL_TURN})
                                           : hsum[HEAD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_out.heading    <= r8_deg ? '0 : hwrap;
        r_out.degenerate <= r8_deg;
    end

    assign o_out   = r_out;
    assign o_valid = r_ovld;

    // ---------------- beat tracking: valid bits along every chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
            r_ovld <= 1'b0;
            for (int k = 0; k < SQ; k++) begin
                r_nv[k] <= 1'b0;
                r_cv[k] <= 1'b0;
            end
            for (int k = 0; k < DV; k++) begin
                r_dv[k] <= 1'b0;
            end
            for (int k = 0; k < NC; k++) begin
                r_kv[k] <= 1'b0;
            end
        end else begin
            r1_vld  <= accept;
            r2_vld  <= r1_vld;
            r_nv[0] <= r2_vld;
            for (int k = 1; k < SQ; k++) begin
                r_nv[k] <= r_nv[k-1];
            end
            r_dv[0] <= r_nv[SQ-1];
            for (int k = 1; k < DV; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r3_vld  <= r_dv[DV-1];
            r_cv[0] <= r3_vld;
            for (int k = 1; k < SQ; k++) begin
                r_cv[k] <= r_cv[k-1];
            end
            r4_vld  <= r_cv[SQ-1];
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r_kv[0] <= r7_vld;
            for (int k = 1; k < NC; k++) begin
                r_kv[k] <= r_kv[k-1];
            end
            r8_vld  <= r_kv[NC-1];
            r_ovld  <= r8_vld;
        end
    end

endmodule

// File: rtl/core/tch_checker.sv
// Port-level checker for the tilt-compensated heading block, bound to the top.
// Depends on tch_pkg and tilt_compensated_heading_macros.svh.
`include "tilt_compensated_heading_macros.svh"

module tch_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        i_busy,
    input tch_pkg::t_in                i_in,
    input logic                        i_valid,
    input tch_pkg::t_out               i_out
);
    import tch_pkg::*;

    logic beat;
    logic zero_acc;

    assign beat     = i_start && !i_busy;
    assign zero_acc = beat && (i_in.accel_x == 16'sd0) && (i_in.accel_y == 16'sd0)
                      && (i_in.accel_z == 16'sd0);

    // every start beat yields a result beat at the fixed latency
    `TCH_ASSERT_IMP(a_beat_out, i_clk, i_rst_n, beat, ##LATENCY i_valid, "result beat missing")

    // no result beat without a start beat at the fixed latency
    `TCH_ASSERT_IMP(a_no_phantom, i_clk, i_rst_n, i_valid, $past(beat, LATENCY), "phantom beat")

    // zero accelerometer vector must come out flagged
    `TCH_ASSERT_IMP(a_zero_accel, i_clk, i_rst_n, zero_acc, ##LATENCY i_out.degenerate, "no flag")

    // a flagged result carries heading zero
    `TCH_ASSERT_IMP(a_deg_zero, i_clk, i_rst_n, i_valid && i_out.degenerate, (i_out.heading == '0), "bad heading")

endmodule

bind tilt_compensated_heading tch_checker u_tch_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (start),
    .i_busy  (busy),
    .i_in    (i_in),
    .i_valid (o_valid),
    .i_out   (o_out)
);
